// ===== rtl/core/olst_pkg.sv =====
// Shared types and codes for the ordered list store.
package olst_pkg;

  localparam logic [2:0] KIND_APPEND = 3'd0;
  localparam logic [2:0] KIND_TEST   = 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd2;
  localparam logic [2:0] KIND_WRITE  = 3'd3;
  localparam logic [2:0] KIND_DELETE = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    logic [2:0]        kind;
    logic [POS_W-1:0]  position;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic signed [31:0]  value_out;
    logic                found;
    logic [COUNT_W-1:0]  entry_count;
    logic                empty_res;
  } out_item_t;

  typedef struct packed {
    logic load;   // take the request value
    logic shift;  // take the neighbor's value
    logic held;   // entry is below the count
    logic sel;    // entry is at the request position
  } cell_ctrl_t;

endpackage

// ===== rtl/core/olst_cell.sv =====
// One list entry: holds a value, loads, shifts from its neighbor, matches and taps.
module olst_cell (
  input  logic                     clk,
  input  olst_pkg::cell_ctrl_t     ctrl,
  input  logic signed [31:0]       req_value,
  input  logic signed [31:0]       shift_in,
  output logic signed [31:0]       value,
  output logic                     match,
  output logic signed [31:0]       tap
);

  logic signed [31:0] value_r;
  logic signed [31:0] value_nxt;

  always_comb begin
    if (ctrl.shift) begin
      value_nxt = shift_in;
    end else if (ctrl.load) begin
      value_nxt = req_value;
    end else begin
      value_nxt = value_r;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;
  assign match = ctrl.held && (value_r == req_value);
  assign tap   = ctrl.sel ? value_r : 32'sd0;

endmodule

// ===== rtl/core/ordered_list_store.sv =====
// Bounded ordered list built as a chain of entry cells with an output register.
// Each result is registered in the cycle after its item is accepted.
// Throughput: one item per cycle unless the input stalls; all cells compare, load or shift in that cycle.
// The input stalls only while a registered result waits on a stalled output.
// Reset (rst_n low, synchronous) empties the list; entry contents are not cleared.
module ordered_list_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  olst_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output olst_pkg::out_item_t   out_item
);

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > olst_pkg::POS_W) ? CW : olst_pkg::POS_W;

  logic [CW-1:0]   count_r;
  logic [CW-1:0]   count_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  olst_pkg::out_item_t out_item_r;
  olst_pkg::out_item_t out_item_nxt;

  logic            acc;
  logic            full;
  logic            pos_ok;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] count_ext;
  logic            do_append;
  logic            do_write;
  logic            do_delete;

  logic signed [31:0] cell_value [DEPTH];
  logic signed [31:0] cell_tap   [DEPTH];
  logic [DEPTH-1:0]   cell_match;
  logic signed [31:0] rd_value;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  assign pos_ext   = CMPW'(in_item.position);
  assign count_ext = CMPW'(count_r);
  assign full      = (count_r == CW'(DEPTH));
  assign pos_ok    = (pos_ext < count_ext);

  assign do_append = acc && (in_item.kind == olst_pkg::KIND_APPEND) && !full;
  assign do_write  = acc && (in_item.kind == olst_pkg::KIND_WRITE) && pos_ok;
  assign do_delete = acc && (in_item.kind == olst_pkg::KIND_DELETE) && pos_ok;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CMPW-1:0] IDX = CMPW'(i);
    olst_pkg::cell_ctrl_t ctrl;
    logic signed [31:0]   neighbor;

    assign ctrl.sel   = (IDX == pos_ext);
    assign ctrl.held  = (IDX < count_ext);
    assign ctrl.load  = (do_append && (IDX == count_ext)) || (do_write && ctrl.sel);
    assign ctrl.shift = do_delete && (IDX >= pos_ext);

    if (i == DEPTH - 1) begin : g_last
      assign neighbor = cell_value[i];
    end else begin : g_mid
      assign neighbor = cell_value[i+1];
    end

    olst_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .req_value (in_item.value),
      .shift_in  (neighbor),
      .value     (cell_value[i]),
      .match     (cell_match[i]),
      .tap       (cell_tap[i])
    );
  end

  always_comb begin
    rd_value = 32'sd0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_value = rd_value | cell_tap[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_append) begin
      count_nxt = CW'(count_r + 1'b1);
    end else if (do_delete) begin
      count_nxt = CW'(count_r - 1'b1);
    end
  end

  always_comb begin
    out_item_nxt.status    = olst_pkg::ST_OK;
    out_item_nxt.value_out = 32'sd0;
    out_item_nxt.found     = 1'b0;
    unique case (in_item.kind) inside
      olst_pkg::KIND_APPEND: begin
        if (full) begin
          out_item_nxt.status = olst_pkg::ST_FULL;
        end else begin
          out_item_nxt.value_out = in_item.value;
        end
      end
      olst_pkg::KIND_TEST: begin
        out_item_nxt.found = |cell_match;
      end
      olst_pkg::KIND_READ, olst_pkg::KIND_DELETE: begin
        if (!pos_ok) begin
          out_item_nxt.status = olst_pkg::ST_INVALID;
        end else begin
          out_item_nxt.value_out = rd_value;
        end
      end
      olst_pkg::KIND_WRITE: begin
        if (!pos_ok) begin
          out_item_nxt.status = olst_pkg::ST_INVALID;
        end else begin
          out_item_nxt.value_out = in_item.value;
        end
      end
      default: begin
      end
    endcase
    out_item_nxt.entry_count = olst_pkg::COUNT_W'(count_nxt);
    out_item_nxt.empty_res   = (count_nxt == '0);
  end

  always_comb begin
    if (acc) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== rtl/core/olst_checker.sv =====
// Port-level assertions for the ordered list store, bound to the top level.
module olst_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input olst_pkg::out_item_t  out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item gave no result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == olst_pkg::ST_FULL) |->
      out_item.entry_count == olst_pkg::COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.empty_res |-> out_item.entry_count == '0)
    else $error("empty flag with nonzero count");

  a_found_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.found |->
      (out_item.status == olst_pkg::ST_OK) && (out_item.value_out == 32'sd0))
    else $error("found result carries status or value");

endmodule

bind ordered_list_store olst_checker #(.DEPTH(DEPTH)) u_olst_checker (.*);

// ===== tb/sv/ordered_list_store_tb.sv =====
// Self-checking testbench for the ordered list store: mirror list, scoreboard and stimulus.
module ordered_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST = 3'd7;

  class list_shadow;
    logic signed [31:0] held_vals [LIST_DEPTH];
    int unsigned held_count;
    olst_pkg::out_item_t pending_replies [$];
    int unsigned mismatches;
    int unsigned requests;
    int unsigned replies;
    int unsigned full_hits;
    int unsigned invalid_hits;
    int unsigned found_hits;
    int unsigned empty_hits;
    int unsigned spare_hits;
    int unsigned kind_seen [8];

    function void note_request(olst_pkg::in_item_t req);
      olst_pkg::out_item_t rep;
      rep = '0;
      rep.status = olst_pkg::ST_OK;
      requests++;
      kind_seen[req.kind]++;
      case (req.kind) inside
        olst_pkg::KIND_APPEND: begin
          if (held_count >= LIST_DEPTH) begin
            rep.status = olst_pkg::ST_FULL;
            full_hits++;
          end else begin
            held_vals[held_count] = req.value;
            held_count++;
            rep.value_out = req.value;
          end
        end
        olst_pkg::KIND_TEST: begin
          for (int unsigned i = 0; i < held_count; i++)
            if (held_vals[i] == req.value) rep.found = 1'b1;
          if (rep.found) found_hits++;
        end
        olst_pkg::KIND_READ, olst_pkg::KIND_WRITE, olst_pkg::KIND_DELETE: begin
          if (req.position >= held_count) begin
            rep.status = olst_pkg::ST_INVALID;
            invalid_hits++;
          end else if (req.kind == olst_pkg::KIND_READ) begin
            rep.value_out = held_vals[req.position];
          end else if (req.kind == olst_pkg::KIND_WRITE) begin
            held_vals[req.position] = req.value;
            rep.value_out = req.value;
          end else begin
            rep.value_out = held_vals[req.position];
            for (int unsigned i = 32'(req.position); i + 1 < held_count; i++)
              held_vals[i] = held_vals[i + 1];
            held_count--;
            if (held_count == 0) empty_hits++;
          end
        end
        default: spare_hits++;
      endcase
      rep.entry_count = olst_pkg::COUNT_W'(held_count);
      rep.empty_res = (held_count == 0);
      pending_replies.push_back(rep);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= 50)
        $display("%0t MISMATCH at reply %0d: %s got %h expected %h",
                 $time, replies, field, got, want);
    endtask

    task check_reply(olst_pkg::out_item_t got);
      olst_pkg::out_item_t want;
      replies++;
      if (pending_replies.size() == 0) begin
        report("unexpected result", got.value_out, 32'd0);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.value_out !== want.value_out)
          report("value_out", got.value_out, want.value_out);
        if (got.found !== want.found)
          report("found", 32'(got.found), 32'(want.found));
        if (got.entry_count !== want.entry_count)
          report("entry_count", 32'(got.entry_count), 32'(want.entry_count));
        if (got.empty_res !== want.empty_res)
          report("empty_res", 32'(got.empty_res), 32'(want.empty_res));
      end
    endtask

    task check_drained();
      if (pending_replies.size() != 0)
        report("results never seen", 32'(pending_replies.size()), 32'd0);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  olst_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  olst_pkg::out_item_t out_item;

  bit gaps_on = 1'b1;
  bit hold_start = 1'b0;
  logic signed [31:0] recent_values [$];
  list_shadow shadow = new();

  ordered_list_store #(.DEPTH(LIST_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) shadow.note_request(in_item);
    if (rst_n && out_valid && !out_stall) shadow.check_reply(out_item);
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= gaps_on && ($urandom_range(99) < 10);
      end
    end
  end

  task automatic offer(olst_pkg::in_item_t req);
    if (gaps_on && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (req.kind == olst_pkg::KIND_APPEND || req.kind == olst_pkg::KIND_WRITE) begin
      recent_values.push_back(req.value);
      if (recent_values.size() > LIST_DEPTH) void'(recent_values.pop_front());
    end
  endtask

  task automatic offer_fields(logic [2:0] kind, logic [3:0] pos, logic [31:0] value);
    olst_pkg::in_item_t req;
    req.kind = kind;
    req.position = pos;
    req.value = value;
    offer(req);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  // mode 0 grows the list, mode 1 drains it, mode 2 mixes
  function automatic olst_pkg::in_item_t pick_request(int unsigned mode);
    olst_pkg::in_item_t req;
    int unsigned roll;
    int unsigned app_pct;
    int unsigned del_pct;
    app_pct = (mode == 0) ? 45 : (mode == 1) ? 15 : 25;
    del_pct = (mode == 0) ? 8 : (mode == 1) ? 45 : 25;
    roll = $urandom_range(99);
    req.position = $urandom_range(1) ? 4'($urandom_range(15)) : 4'($urandom_range(7));
    req.value = pick_value();
    if (roll < app_pct) begin
      req.kind = olst_pkg::KIND_APPEND;
    end else if (roll < app_pct + del_pct) begin
      req.kind = olst_pkg::KIND_DELETE;
    end else if (roll < 97) begin
      case ($urandom_range(2))
        0: req.kind = olst_pkg::KIND_TEST;
        1: req.kind = olst_pkg::KIND_READ;
        default: req.kind = olst_pkg::KIND_WRITE;
      endcase
    end else begin
      req.kind = 3'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    end
    if (req.kind == olst_pkg::KIND_TEST && recent_values.size() != 0 &&
        $urandom_range(99) < 60)
      req.value = recent_values[$urandom_range(recent_values.size() - 1)];
    return req;
  endfunction

  initial begin
    int unsigned spins;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    offer_fields(olst_pkg::KIND_READ, 4'd0, 32'd0);
    offer_fields(olst_pkg::KIND_DELETE, 4'd0, 32'd0);
    offer_fields(olst_pkg::KIND_TEST, 4'd0, 32'd0);
    for (int k = 0; k < LIST_DEPTH; k++) begin
      case (k)
        0: offer_fields(olst_pkg::KIND_APPEND, 4'hf, 32'h8000_0000);
        1: offer_fields(olst_pkg::KIND_APPEND, 4'd0, 32'h7fff_ffff);
        2: offer_fields(olst_pkg::KIND_APPEND, 4'd0, 32'hffff_ffff);
        3: offer_fields(olst_pkg::KIND_APPEND, 4'd0, 32'h0000_0000);
        default: offer_fields(olst_pkg::KIND_APPEND, 4'd0, $urandom());
      endcase
    end
    offer_fields(olst_pkg::KIND_APPEND, 4'd0, 32'h1234_5678);
    offer_fields(olst_pkg::KIND_TEST, 4'd0, 32'hffff_ffff);
    offer_fields(olst_pkg::KIND_READ, 4'(LIST_DEPTH - 1), 32'd0);
    offer_fields(olst_pkg::KIND_WRITE, 4'(LIST_DEPTH - 1), 32'h7fff_ffff);
    offer_fields(olst_pkg::KIND_DELETE, 4'd0, 32'd0);
    offer_fields(olst_pkg::KIND_READ, 4'(LIST_DEPTH - 1), 32'd0);
    offer_fields(KIND_SPARE_FIRST, 4'd3, 32'hdead_beef);
    offer_fields(KIND_SPARE_LAST, 4'hf, 32'hffff_ffff);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 300) gaps_on = 1'b0;
      if (n == 550) gaps_on = 1'b1;
      if (n == 700) hold_start = 1'b1;
      offer(pick_request((n / 80) % 3));
    end
    in_valid <= 1'b0;

    spins = 0;
    while (shadow.pending_replies.size() != 0 && spins < 2000) begin
      @(posedge clk);
      spins++;
    end
    repeat (4) @(posedge clk);
    shadow.check_drained();

    $display("Run covered %0d requests: %0d appends, %0d tests, %0d reads,",
             shadow.requests, shadow.kind_seen[olst_pkg::KIND_APPEND],
             shadow.kind_seen[olst_pkg::KIND_TEST], shadow.kind_seen[olst_pkg::KIND_READ]);
    $display("  %0d writes, %0d deletes, %0d unused codes; %0d results checked.",
             shadow.kind_seen[olst_pkg::KIND_WRITE], shadow.kind_seen[olst_pkg::KIND_DELETE],
             shadow.spare_hits, shadow.replies);
    $display("Saw %0d appends to a full list, %0d bad positions, %0d test hits, %0d empties.",
             shadow.full_hits, shadow.invalid_hits, shadow.found_hits, shadow.empty_hits);
    if (shadow.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Timeout: run did not finish in time");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/olst_pkg.sv
rtl/core/olst_cell.sv
rtl/core/ordered_list_store.sv
rtl/core/olst_checker.sv
tb/sv/ordered_list_store_tb.sv
